FILE: rtl/cre_pkg.sv
`timescale 1ns / 1ps
// cre_pkg: shared types and constants for the complex RPN evaluator.
// No dependencies.

package cre_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int DATA_W    = 32;
    localparam int ENTRY_W   = 2 * DATA_W;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int DIV_STEPS = DATA_W;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    localparam logic [STEP_W-1:0] PROD_MUL  = STEP_W'(4);
    localparam logic [STEP_W-1:0] PROD_DIV  = STEP_W'(6);
    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DIV_STEPS - 1);

    localparam logic [2:0] KIND_OPERAND = 3'd0;
    localparam logic [2:0] KIND_ADD     = 3'd1;
    localparam logic [2:0] KIND_SUB     = 3'd2;
    localparam logic [2:0] KIND_MUL     = 3'd3;
    localparam logic [2:0] KIND_DIV     = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_OVER  = 2'd2;
    localparam logic [1:0] ST_DIVZ  = 2'd3;

    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_EXEC,
        S_MULT,
        S_MUL_WB,
        S_DIV_SET,
        S_DIV_RUN,
        S_DIV_WB,
        S_TOP,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [PROD_W-1:0] rem;
        logic [DATA_W-1:0] dq;
    } div_lane_t;

endpackage

FILE: rtl/complex_rpn_evaluator.sv
`timescale 1ns / 1ps
// complex_rpn_evaluator: postfix evaluator over complex Q15.16 values.
// Depends on cre_pkg.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+------------------------------
//   in       | input     | in_valid / in_ready  | kind, value_re, value_im, last
//   out      | output    | out_valid / out_ready| answer_re, answer_im, status
//
// Multiply and divide share one 32x32 multiplier (one product per cycle, up to
// six); divide then runs a radix-2 restoring divider, 32 steps, both lanes together.
// The stack is a two-read, one-write memory with registered read data.
// Reset clears the fill count, the error, the step count, the product-valid flag and the handshake state only.
// in_ready is high in idle only; a result waiting on out_ready does not stall intake
// until the next result load, which waits for it with in_ready low.

module complex_rpn_evaluator
    import cre_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [2:0]               kind,
    input  logic signed [DATA_W-1:0] value_re,
    input  logic signed [DATA_W-1:0] value_im,
    input  logic                     last,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] answer_re,
    output logic signed [DATA_W-1:0] answer_im,
    output logic [1:0]               status
);

    localparam int AW       = $clog2(STACK_DEPTH);
    localparam int CW       = $clog2(STACK_DEPTH + 1);
    localparam int DVD_W    = PROD_W + FRAC_BITS;

    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

    // stack memory
    logic [ENTRY_W-1:0] mem [STACK_DEPTH];

    state_t state_reg, state_next;

    logic [CW-1:0]     count_reg, count_next;
    logic [1:0]        err_reg, err_next;
    logic [2:0]        kind_reg;
    logic              last_reg;
    logic [ENTRY_W-1:0] rd_a_reg, rd_b_reg;
    logic [STEP_W-1:0] step_reg;
    logic              prod_vld_reg;
    logic [2:0]        prod_idx_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_re_reg, acc_im_reg;
    logic [PROD_W-1:0] den_reg;
    div_lane_t         lane_re_reg, lane_im_reg;
    logic              neg_re_reg, neg_im_reg, ovf_re_reg, ovf_im_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] answer_re_reg, answer_im_reg;
    logic [1:0]        status_reg;

    // control
    logic              push_en, note_en, rd_a_en, rd_b_en, wb_en;
    logic              acc_clr, mult_run, div_load, div_run, emit_fire;
    logic [1:0]        note_code;
    logic [ENTRY_W-1:0] wb_data;

    logic [CW-1:0]     cnt_m1, cnt_m2;
    logic [AW-1:0]     addr_a, addr_b, wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic              is_op;
    logic [STEP_W-1:0] nprod;
    logic [DATA_W-1:0] ar, ai, br, bi;
    logic signed [DATA_W-1:0] mul_x, mul_y;
    logic signed [ACC_W-1:0]  prod_ext;
    logic [DATA_W-1:0] addsub_re, addsub_im, mul_re, mul_im, div_re, div_im;
    logic [PROD_W-1:0] mag_re, mag_im;
    logic [DVD_W-1:0]  dvd_re, dvd_im;
    logic [PROD_W-1:0] hi_re, hi_im;

    function automatic logic signed [ACC_W-1:0] sx(input logic [DATA_W-1:0] v);
        return {{(ACC_W-DATA_W){v[DATA_W-1]}}, v};
    endfunction

    function automatic logic [DATA_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
        logic [DATA_W-1:0] r;
        if ((&v[ACC_W-1:DATA_W-1]) || !(|v[ACC_W-1:DATA_W-1])) begin
            r = v[DATA_W-1:0];
        end
        else begin
            r = v[ACC_W-1] ? SAT_MIN : SAT_MAX;
        end
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] sat_quot(input logic neg, input logic ovf,
                                                   input logic [DATA_W-1:0] q);
        logic [DATA_W-1:0] r;
        if (ovf || q[DATA_W-1]) begin
            r = neg ? SAT_MIN : SAT_MAX;
        end
        else begin
            r = neg ? (~q + DATA_W'(1)) : q;
        end
        return r;
    endfunction

    function automatic div_lane_t div_step(input div_lane_t l, input logic [PROD_W-1:0] den);
        logic [PROD_W+1:0] diff;
        logic              ge;
        div_lane_t         r;
        diff = {1'b0, l.rem, l.dq[DATA_W-1]} - {2'b00, den};
        ge   = ~diff[PROD_W+1];
        r.rem = ge ? diff[PROD_W-1:0] : {l.rem[PROD_W-2:0], l.dq[DATA_W-1]};
        r.dq  = {l.dq[DATA_W-2:0], ge};
        return r;
    endfunction

    assign cnt_m1  = count_reg - CW'(1);
    assign cnt_m2  = count_reg - CW'(2);
    assign addr_b  = cnt_m1[AW-1:0];
    assign addr_a  = cnt_m2[AW-1:0];
    assign is_op   = (kind == KIND_ADD) || (kind == KIND_SUB) ||
                     (kind == KIND_MUL) || (kind == KIND_DIV);
    assign nprod   = (kind_reg == KIND_MUL) ? PROD_MUL : PROD_DIV;

    assign ar = rd_a_reg[ENTRY_W-1:DATA_W];
    assign ai = rd_a_reg[DATA_W-1:0];
    assign br = rd_b_reg[ENTRY_W-1:DATA_W];
    assign bi = rd_b_reg[DATA_W-1:0];

    assign addsub_re = (kind_reg == KIND_SUB) ? sat_acc(sx(ar) - sx(br)) : sat_acc(sx(ar) + sx(br));
    assign addsub_im = (kind_reg == KIND_SUB) ? sat_acc(sx(ai) - sx(bi)) : sat_acc(sx(ai) + sx(bi));
    assign mul_re    = sat_acc(acc_re_reg >>> FRAC_BITS);
    assign mul_im    = sat_acc(acc_im_reg >>> FRAC_BITS);
    assign div_re    = sat_quot(neg_re_reg, ovf_re_reg, lane_re_reg.dq);
    assign div_im    = sat_quot(neg_im_reg, ovf_im_reg, lane_im_reg.dq);

    // numerator magnitude never exceeds 2^63
    assign mag_re = acc_re_reg[ACC_W-1] ? PROD_W'(-acc_re_reg) : PROD_W'(acc_re_reg);
    assign mag_im = acc_im_reg[ACC_W-1] ? PROD_W'(-acc_im_reg) : PROD_W'(acc_im_reg);
    assign dvd_re = {mag_re, {FRAC_BITS{1'b0}}};
    assign dvd_im = {mag_im, {FRAC_BITS{1'b0}}};
    assign hi_re  = PROD_W'(dvd_re[DVD_W-1:DATA_W]);
    assign hi_im  = PROD_W'(dvd_im[DVD_W-1:DATA_W]);

    assign prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_comb
    begin
        case (step_reg[2:0])
            3'd0:
            begin
                mul_x = ar;
                mul_y = br;
            end
            3'd1:
            begin
                mul_x = ai;
                mul_y = bi;
            end
            3'd2:
            begin
                mul_x = ai;
                mul_y = br;
            end
            3'd3:
            begin
                mul_x = ar;
                mul_y = bi;
            end
            3'd4:
            begin
                mul_x = br;
                mul_y = br;
            end
            3'd5:
            begin
                mul_x = bi;
                mul_y = bi;
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid) begin
                    if (is_op && (count_reg >= CW'(2))) begin
                        state_next = S_LOAD;
                    end
                    else if (last) begin
                        state_next = S_TOP;
                    end
                end
            end
            S_LOAD:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if ((kind_reg == KIND_MUL) || (kind_reg == KIND_DIV)) begin
                    state_next = S_MULT;
                end
                else begin
                    state_next = last_reg ? S_TOP : S_IDLE;
                end
            end
            S_MULT:
            begin
                if (step_reg == nprod) begin
                    state_next = (kind_reg == KIND_MUL) ? S_MUL_WB : S_DIV_SET;
                end
            end
            S_MUL_WB, S_DIV_WB:
            begin
                state_next = last_reg ? S_TOP : S_IDLE;
            end
            S_DIV_SET:
            begin
                if (den_reg == '0) begin
                    state_next = last_reg ? S_TOP : S_IDLE;
                end
                else begin
                    state_next = S_DIV_RUN;
                end
            end
            S_DIV_RUN:
            begin
                if (step_reg == DIV_LAST) begin
                    state_next = S_DIV_WB;
                end
            end
            S_TOP:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready) begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        in_ready  = 1'b0;
        push_en   = 1'b0;
        note_en   = 1'b0;
        note_code = ST_OK;
        rd_a_en   = 1'b0;
        rd_b_en   = 1'b0;
        wb_en     = 1'b0;
        wb_data   = '0;
        acc_clr   = 1'b0;
        mult_run  = 1'b0;
        div_load  = 1'b0;
        div_run   = 1'b0;
        emit_fire = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (kind == KIND_OPERAND) begin
                        if (count_reg >= DEPTH_C) begin
                            note_en   = 1'b1;
                            note_code = ST_OVER;
                        end
                        else begin
                            push_en = 1'b1;
                        end
                    end
                    else if (is_op && (count_reg < CW'(2))) begin
                        note_en   = 1'b1;
                        note_code = ST_UNDER;
                    end
                end
            end
            S_LOAD:
            begin
                rd_a_en = 1'b1;
                rd_b_en = 1'b1;
            end
            S_EXEC:
            begin
                if ((kind_reg == KIND_MUL) || (kind_reg == KIND_DIV)) begin
                    acc_clr = 1'b1;
                end
                else begin
                    wb_en   = 1'b1;
                    wb_data = {addsub_re, addsub_im};
                end
            end
            S_MULT:
            begin
                mult_run = 1'b1;
            end
            S_MUL_WB:
            begin
                wb_en   = 1'b1;
                wb_data = {mul_re, mul_im};
            end
            S_DIV_SET:
            begin
                if (den_reg == '0) begin
                    note_en   = 1'b1;
                    note_code = ST_DIVZ;
                    wb_en     = 1'b1;
                end
                else begin
                    div_load = 1'b1;
                end
            end
            S_DIV_RUN:
            begin
                div_run = 1'b1;
            end
            S_DIV_WB:
            begin
                wb_en   = 1'b1;
                wb_data = {div_re, div_im};
            end
            S_TOP:
            begin
                rd_b_en = (count_reg != '0);
            end
            S_EMIT:
            begin
                emit_fire = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (emit_fire) begin
            count_next = '0;
        end
        else if (push_en) begin
            count_next = count_reg + CW'(1);
        end
        else if (wb_en) begin
            count_next = cnt_m1;
        end
    end

    always_comb
    begin
        err_next = err_reg;
        if (emit_fire) begin
            err_next = ST_OK;
        end
        else if (note_en && (err_reg == ST_OK)) begin
            err_next = note_code;
        end
    end

    assign wr_addr = push_en ? count_reg[AW-1:0] : addr_a;
    assign wr_data = push_en ? {value_re, value_im} : wb_data;

    always_ff @(posedge clk)
    begin
        if (push_en || wb_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_a_en) begin
            rd_a_reg <= mem[addr_a];
        end
        if (rd_b_en) begin
            rd_b_reg <= mem[addr_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            err_reg       <= ST_OK;
            step_reg      <= '0;
            prod_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            err_reg      <= err_next;
            prod_vld_reg <= mult_run && (step_reg < nprod);
            if (acc_clr || div_load) begin
                step_reg <= '0;
            end
            else if (mult_run || div_run) begin
                step_reg <= step_reg + STEP_W'(1);
            end
            if (emit_fire) begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            kind_reg <= kind;
            last_reg <= last;
        end
        prod_reg     <= mul_x * mul_y;
        prod_idx_reg <= step_reg[2:0];
        if (acc_clr) begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
            den_reg    <= '0;
        end
        else if (prod_vld_reg) begin
            case (prod_idx_reg)
                3'd0:
                begin
                    acc_re_reg <= acc_re_reg + prod_ext;
                end
                3'd1:
                begin
                    if (kind_reg == KIND_MUL) begin
                        acc_re_reg <= acc_re_reg - prod_ext;
                    end
                    else begin
                        acc_re_reg <= acc_re_reg + prod_ext;
                    end
                end
                3'd2:
                begin
                    acc_im_reg <= acc_im_reg + prod_ext;
                end
                3'd3:
                begin
                    if (kind_reg == KIND_MUL) begin
                        acc_im_reg <= acc_im_reg + prod_ext;
                    end
                    else begin
                        acc_im_reg <= acc_im_reg - prod_ext;
                    end
                end
                3'd4, 3'd5:
                begin
                    den_reg <= den_reg + prod_reg;
                end
                default:
                begin
                    den_reg <= den_reg;
                end
            endcase
        end
        if (div_load) begin
            neg_re_reg      <= acc_re_reg[ACC_W-1];
            neg_im_reg      <= acc_im_reg[ACC_W-1];
            ovf_re_reg      <= (hi_re >= den_reg);
            ovf_im_reg      <= (hi_im >= den_reg);
            lane_re_reg.rem <= hi_re;
            lane_im_reg.rem <= hi_im;
            lane_re_reg.dq  <= dvd_re[DATA_W-1:0];
            lane_im_reg.dq  <= dvd_im[DATA_W-1:0];
        end
        else if (div_run) begin
            lane_re_reg <= div_step(lane_re_reg, den_reg);
            lane_im_reg <= div_step(lane_im_reg, den_reg);
        end
        if (emit_fire) begin
            answer_re_reg <= (count_reg == '0) ? '0 : rd_b_reg[ENTRY_W-1:DATA_W];
            answer_im_reg <= (count_reg == '0) ? '0 : rd_b_reg[DATA_W-1:0];
            if (err_reg != ST_OK) begin
                status_reg <= err_reg;
            end
            else if (count_reg == '0) begin
                status_reg <= ST_UNDER;
            end
            else begin
                status_reg <= ST_OK;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign answer_re = answer_re_reg;
    assign answer_im = answer_im_reg;
    assign status    = status_reg;

endmodule

FILE: tb/rpn_answer_checker.sv
`timescale 1ns / 1ps
// rpn_answer_checker: watches both channels of complex_rpn_evaluator, predicts each answer
// word from the accepted token words and compares it field by field. Depends on cre_pkg.

module rpn_answer_checker
    import cre_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic [2:0]               kind,
    input  logic signed [DATA_W-1:0] value_re,
    input  logic signed [DATA_W-1:0] value_im,
    input  logic                     last,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic signed [DATA_W-1:0] answer_re,
    input  logic signed [DATA_W-1:0] answer_im,
    input  logic [1:0]               status,
    output int                       mismatches,
    output int                       answers_pending
);

    typedef logic signed [79:0] wide_t;

    typedef struct {
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
        logic [1:0]               st;
    } answer_t;

    answer_t            answers_due[$];
    logic [ENTRY_W-1:0] stack_mem[STACK_DEPTH];
    int                 depth;
    logic [1:0]         err_code;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic logic [DATA_W-1:0] clamp_word(input wide_t v);
        if (v > wide_t'($signed(SAT_MAX)))
            return SAT_MAX;
        if (v < wide_t'($signed(SAT_MIN)))
            return SAT_MIN;
        return v[DATA_W-1:0];
    endfunction

    // num * 2^FRAC_BITS / den, truncated toward zero, saturated
    function automatic logic [DATA_W-1:0] scaled_quotient(input wide_t num, input wide_t den);
        logic [127:0]       mag;
        logic [127:0]       q;
        logic [DATA_W-1:0]  low;
        mag = (num < 0) ? 128'(-num) : 128'(num);
        q   = (mag << FRAC_BITS) / 128'(den);
        low = q[DATA_W-1:0];
        if (num >= 0)
            return (q > 128'(SAT_MAX)) ? SAT_MAX : low;
        return (q >= 128'(SAT_MIN)) ? SAT_MIN : -low;
    endfunction

    function automatic void note_error(input logic [1:0] code);
        if (err_code == ST_OK)
            err_code = code;
    endfunction

    task automatic evaluate_token(input logic [2:0] k, input logic signed [DATA_W-1:0] vre,
                                  input logic signed [DATA_W-1:0] vim, input logic lst);
        wide_t             ar, ai, br, bi, den;
        logic [DATA_W-1:0] rr, ri;
        answer_t           ans;
        rr = '0;
        ri = '0;
        if (k == KIND_OPERAND)
        begin
            if (depth >= STACK_DEPTH)
                note_error(ST_OVER);
            else
            begin
                stack_mem[depth] = {vre, vim};
                depth++;
            end
        end
        else if (k <= KIND_DIV)
        begin
            if (depth < 2)
                note_error(ST_UNDER);
            else
            begin
                br = $signed(stack_mem[depth-1][ENTRY_W-1:DATA_W]);
                bi = $signed(stack_mem[depth-1][DATA_W-1:0]);
                ar = $signed(stack_mem[depth-2][ENTRY_W-1:DATA_W]);
                ai = $signed(stack_mem[depth-2][DATA_W-1:0]);
                depth -= 2;
                case (k)
                    KIND_ADD:
                    begin
                        rr = clamp_word(ar + br);
                        ri = clamp_word(ai + bi);
                    end
                    KIND_SUB:
                    begin
                        rr = clamp_word(ar - br);
                        ri = clamp_word(ai - bi);
                    end
                    KIND_MUL:
                    begin
                        rr = clamp_word((ar * br - ai * bi) >>> FRAC_BITS);
                        ri = clamp_word((ai * br + ar * bi) >>> FRAC_BITS);
                    end
                    default:
                    begin
                        den = br * br + bi * bi;
                        if (den == 0)
                            note_error(ST_DIVZ);
                        else
                        begin
                            rr = scaled_quotient(ar * br + ai * bi, den);
                            ri = scaled_quotient(ai * br - ar * bi, den);
                        end
                    end
                endcase
                stack_mem[depth] = {rr, ri};
                depth++;
            end
        end
        if (lst)
        begin
            ans.re = '0;
            ans.im = '0;
            if (depth > 0)
            begin
                ans.re = stack_mem[depth-1][ENTRY_W-1:DATA_W];
                ans.im = stack_mem[depth-1][DATA_W-1:0];
            end
            if (err_code != ST_OK)
                ans.st = err_code;
            else if (depth == 0)
                ans.st = ST_UNDER;
            else
                ans.st = ST_OK;
            answers_due.push_back(ans);
            depth    = 0;
            err_code = ST_OK;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            answers_due.delete();
            depth    = 0;
            err_code = ST_OK;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (answers_due.size() == 0)
                    report_mismatch($sformatf("answer word %h %h %h with none pending",
                                              answer_re, answer_im, status));
                else
                begin
                    if (answer_re !== answers_due[0].re)
                        report_mismatch($sformatf("answer_re got %h expected %h",
                                                  answer_re, answers_due[0].re));
                    if (answer_im !== answers_due[0].im)
                        report_mismatch($sformatf("answer_im got %h expected %h",
                                                  answer_im, answers_due[0].im));
                    if (status !== answers_due[0].st)
                        report_mismatch($sformatf("status got %0d expected %0d",
                                                  status, answers_due[0].st));
                    void'(answers_due.pop_front());
                end
            end
            if (in_valid && in_ready)
                evaluate_token(kind, value_re, value_im, last);
        end
        answers_pending = answers_due.size();
    end

endmodule

FILE: tb/tb_complex_rpn_evaluator.sv
`timescale 1ns / 1ps
// tb_complex_rpn_evaluator: drives token words into complex_rpn_evaluator under random
// idling and back-pressure and gives the verdict. Depends on cre_pkg, complex_rpn_evaluator, rpn_answer_checker.

module tb_complex_rpn_evaluator
    import cre_pkg::*;
();

    localparam int LIMIT       = 800000;
    localparam int WORD_TARGET = 1250;
    localparam int LONG_HOLD   = 600;
    localparam int TAIL_CYCLES = 60;

    localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
    localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    logic [2:0]               kind      = KIND_OPERAND;
    logic signed [DATA_W-1:0] value_re  = '0;
    logic signed [DATA_W-1:0] value_im  = '0;
    logic                     last      = 1'b0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [DATA_W-1:0] answer_re;
    logic signed [DATA_W-1:0] answer_im;
    logic [1:0]               status;

    int mismatches;
    int answers_pending;
    int send_idle_pct = 38;
    int recv_idle_pct = 67;
    int words_sent    = 0;
    int hold_count    = 0;
    int cycle_count   = 0;
    bit hold_go       = 1'b0;

    complex_rpn_evaluator DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .value_re  (value_re),
        .value_im  (value_im),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .answer_re (answer_re),
        .answer_im (answer_im),
        .status    (status)
    );

    rpn_answer_checker answer_check
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .value_re        (value_re),
        .value_im        (value_im),
        .last            (last),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .answer_re       (answer_re),
        .answer_im       (answer_im),
        .status          (status),
        .mismatches      (mismatches),
        .answers_pending (answers_pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: random back-pressure, or a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_go)
        begin
            hold_go    = 1'b0;
            hold_count = LONG_HOLD;
        end
        if (hold_count > 0)
        begin
            hold_count--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    function automatic logic signed [DATA_W-1:0] pick_part();
        case ($urandom_range(9))
            0:       return SAT_MAX;
            1:       return SAT_MIN;
            2:       return '0;
            3:       return $signed($urandom_range(32'h80000)) - 32'sh40000;
            4, 5, 6: return $signed($urandom_range(32'h2000000)) - 32'sh1000000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_operator();
        return 3'($urandom_range(KIND_ADD, KIND_DIV));
    endfunction

    // valid stays high between back-to-back words; lowered only for a gap
    task automatic send_word(input logic [2:0] k, input logic signed [DATA_W-1:0] re,
                             input logic signed [DATA_W-1:0] im, input logic lst);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        kind     <= k;
        value_re <= re;
        value_im <= im;
        last     <= lst;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
    endtask

    task automatic send_operand(input logic lst);
        if ($urandom_range(11) == 0)
            send_word(KIND_OPERAND, '0, '0, lst);
        else
            send_word(KIND_OPERAND, pick_part(), pick_part(), lst);
    endtask

    // well-formed postfix expression, last on its final token
    task automatic send_expression();
        int   n_operands;
        int   pushed;
        int   depth;
        logic done;
        n_operands = ($urandom_range(9) == 0) ? $urandom_range(7, STACK_DEPTH_DEF)
                                              : $urandom_range(1, 5);
        pushed = 0;
        depth  = 0;
        done   = 1'b0;
        while (!done)
        begin
            if (pushed < n_operands && (depth < 2 || $urandom_range(1) == 0))
            begin
                pushed++;
                depth++;
                done = (pushed == n_operands && depth == 1);
                send_operand(done);
            end
            else
            begin
                depth--;
                done = (pushed == n_operands && depth == 1);
                send_word(pick_operator(), $urandom, $urandom, done);
            end
        end
    endtask

    task automatic run_random(input int upto);
        int n;
        while (words_sent < upto)
        begin
            case ($urandom_range(19))
                0:
                begin
                    // overflow
                    n = $urandom_range(STACK_DEPTH_DEF + 1, STACK_DEPTH_DEF + 4);
                    repeat (n) send_operand(1'b0);
                    repeat ($urandom_range(2)) send_word(pick_operator(), '0, '0, 1'b0);
                    send_word(pick_operator(), $urandom, $urandom, 1'b1);
                end
                1:
                begin
                    // operator on an empty stack, then a sticky underflow
                    send_word(pick_operator(), $urandom, $urandom, 1'b0);
                    send_expression();
                end
                2:
                begin
                    repeat ($urandom_range(1, 6))
                        send_word(3'($urandom), pick_part(), pick_part(),
                                  $urandom_range(3) == 0);
                    send_word(3'($urandom), pick_part(), pick_part(), 1'b1);
                end
                3:
                begin
                    // leftover entries below the top
                    repeat ($urandom_range(1, 4)) send_operand(1'b0);
                    send_operand(1'b1);
                end
                default:
                    send_expression();
            endcase
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (answers_pending != 0);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty stack at the end, underflow on the last word
        send_word(KIND_UNUSED_HI, $urandom, $urandom, 1'b1);
        send_word(KIND_ADD, $urandom, $urandom, 1'b1);

        // divide by zero
        send_word(KIND_OPERAND, SAT_MAX, SAT_MIN, 1'b0);
        send_word(KIND_OPERAND, '0, '0, 1'b0);
        send_word(KIND_DIV, '0, '0, 1'b1);

        // full stack of extremes, dropped operand, every operator, leftovers
        for (int i = 0; i <= STACK_DEPTH_DEF; i++)
            send_word(KIND_OPERAND, (i % 2) ? SAT_MIN : SAT_MAX,
                      (i % 3 == 0) ? SAT_MIN : SAT_MAX, 1'b0);
        send_word(KIND_SUB, SAT_MAX, SAT_MAX, 1'b0);
        send_word(KIND_UNUSED_LO, '1, '0, 1'b0);
        send_word(KIND_ADD, '0, '1, 1'b0);
        send_word(KIND_MUL, SAT_MIN, SAT_MIN, 1'b0);
        send_word(KIND_DIV, SAT_MIN, SAT_MAX, 1'b1);

        // receiver holds off while words keep coming
        hold_go = 1'b1;
        run_random(words_sent + 40);
        wait_drained();

        run_random(WORD_TARGET / 3);
        wait_drained();

        send_idle_pct = 67;
        recv_idle_pct = 38;
        run_random(2 * WORD_TARGET / 3);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(WORD_TARGET);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && answers_pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
